// ===== design/tgac_pkg.sv =====
`default_nettype none

package tgac_pkg;

    localparam int SCREEN_WIDTH_DEF = 240;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 24;

    localparam logic [23:0] FONT_BASE_RESET = 24'h020000;

    localparam logic [31:0] OFS_ASC16 = 32'h0000_0000;
    localparam logic [31:0] OFS_ASC32 = 32'h0000_0806;
    localparam logic [31:0] OFS_HZK16 = 32'h0000_280C;
    localparam logic [31:0] OFS_HZK32 = 32'h0004_2652;

    localparam logic signed [15:0] GB_FIRST = 16'sh00A1;
    localparam logic signed [15:0] GB_ROW   = 16'sd94;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FONT_SIZE_MODE    = 1'b0,
        CFG_FONT_BASE_ADDRESS = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic        font_size_mode;
        logic [23:0] font_base_address;
    } font_cfg_t;

    typedef struct packed {
        logic [7:0]  text_byte;
        logic        string_start;
        logic [15:0] start_x;
        logic [15:0] start_y;
    } text_beat_t;

    typedef struct packed {
        logic [31:0] glyph_address;
        logic [7:0]  glyph_bytes;
        logic [5:0]  glyph_width;
        logic [5:0]  glyph_height;
        logic [15:0] draw_x;
        logic [15:0] draw_y;
        logic        is_wide_char;
    } glyph_beat_t;

endpackage

`default_nettype wire

// ===== design/tgac_cfg_regs.sv =====
`default_nettype none

module tgac_cfg_regs
    import tgac_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output font_cfg_t                   font_cfg
);

    font_cfg_t font_cfg_reg;
    font_cfg_t font_cfg_next;

    assign cfg_ready = 1'b1;
    assign font_cfg  = font_cfg_reg;

    always_comb
    begin
        font_cfg_next = font_cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FONT_SIZE_MODE:    font_cfg_next.font_size_mode    = cfg_data[0];
                CFG_FONT_BASE_ADDRESS: font_cfg_next.font_base_address = cfg_data[23:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_cfg_reg.font_size_mode    <= 1'b0;
            font_cfg_reg.font_base_address <= FONT_BASE_RESET;
        end
        else
        begin
            font_cfg_reg <= font_cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/tgac_in_reg.sv =====
`default_nettype none

module tgac_in_reg
    import tgac_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire text_beat_t in_beat,
    input  wire logic       advance,
    output logic            held_valid,
    output text_beat_t      held_beat
);

    logic       valid_reg;
    logic       valid_next;
    text_beat_t beat_reg;
    logic       accept;

    assign in_stall   = valid_reg && !advance;
    assign accept     = in_valid && !in_stall;
    assign held_valid = valid_reg;
    assign held_beat  = beat_reg;

    always_comb
    begin
        priority if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            beat_reg <= in_beat;
    end

endmodule

`default_nettype wire

// ===== design/tgac_glyph_unit.sv =====
`default_nettype none

module tgac_glyph_unit
    import tgac_pkg::*;
#(
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire font_cfg_t  font_cfg,
    input  wire logic       fire,
    input  wire text_beat_t beat,
    output logic            emit,
    output glyph_beat_t     result
);

    localparam logic [15:0] SCREEN_W16 = 16'(SCREEN_WIDTH);

    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [7:0]  held_reg, held_next;
    logic        lead_reg, lead_next;
    logic        ended_reg, ended_next;

    logic [15:0] col_eff, row_eff;
    logic        lead_eff, ended_eff;
    logic        emit_wide, emit_asc;
    logic        big;

    logic signed [15:0] lead_ofs, trail_ofs, gb_index;
    logic [31:0] index32, scaled, table_ofs;
    logic [7:0]  nbytes;
    logic [5:0]  w, h;
    logic [15:0] col_adv;
    logic        wrap;

    assign big       = font_cfg.font_size_mode;
    assign col_eff   = beat.string_start ? beat.start_x : col_reg;
    assign row_eff   = beat.string_start ? beat.start_y : row_reg;
    assign lead_eff  = beat.string_start ? 1'b0 : lead_reg;
    assign ended_eff = beat.string_start ? 1'b0 : ended_reg;

    assign emit_wide = !ended_eff && lead_eff;
    assign emit_asc  = !ended_eff && !lead_eff && (beat.text_byte != 8'd0)
                       && !beat.text_byte[7];
    assign emit      = emit_wide || emit_asc;

    // gb2312 index, kept signed so odd lead/trail values wrap as 32-bit
    assign lead_ofs  = $signed({8'd0, held_reg}) - GB_FIRST;
    assign trail_ofs = $signed({8'd0, beat.text_byte}) - GB_FIRST;
    assign gb_index  = 16'(lead_ofs * GB_ROW) + trail_ofs;
    assign index32   = emit_wide ? {{16{gb_index[15]}}, gb_index}
                                 : {24'd0, beat.text_byte};

    always_comb
    begin
        unique case ({emit_wide, big})
            2'b00:
            begin
                table_ofs = OFS_ASC16;
                scaled    = index32 << 4;
                nbytes    = 8'd16;
                w         = 6'd8;
                h         = 6'd16;
            end
            2'b01:
            begin
                table_ofs = OFS_ASC32;
                scaled    = index32 << 6;
                nbytes    = 8'd64;
                w         = 6'd16;
                h         = 6'd32;
            end
            2'b10:
            begin
                table_ofs = OFS_HZK16;
                scaled    = index32 << 5;
                nbytes    = 8'd32;
                w         = 6'd16;
                h         = 6'd16;
            end
            2'b11:
            begin
                table_ofs = OFS_HZK32;
                scaled    = index32 << 7;
                nbytes    = 8'd128;
                w         = 6'd32;
                h         = 6'd32;
            end
        endcase
    end

    assign col_adv = col_eff + {10'd0, w};
    assign wrap    = col_adv >= (SCREEN_W16 - {10'd0, w});

    always_comb
    begin
        result.glyph_address = {8'd0, font_cfg.font_base_address} + table_ofs + scaled;
        result.glyph_bytes   = nbytes;
        result.glyph_width   = w;
        result.glyph_height  = h;
        result.draw_x        = col_eff;
        result.draw_y        = row_eff;
        result.is_wide_char  = emit_wide;
    end

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        held_next  = held_reg;
        lead_next  = lead_reg;
        ended_next = ended_reg;
        if (fire)
        begin
            col_next   = col_eff;
            row_next   = row_eff;
            lead_next  = lead_eff;
            ended_next = ended_eff;
            priority if (ended_eff)
            begin
                ended_next = 1'b1;
            end
            else if (emit)
            begin
                lead_next = 1'b0;
                col_next  = wrap ? 16'd0 : col_adv;
                row_next  = wrap ? row_eff + {10'd0, h} : row_eff;
            end
            else if (beat.text_byte == 8'd0)
            begin
                ended_next = 1'b1;
            end
            else
            begin
                held_next = beat.text_byte;
                lead_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= 16'd0;
            row_reg   <= 16'd0;
            held_reg  <= 8'd0;
            lead_reg  <= 1'b0;
            ended_reg <= 1'b1;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            held_reg  <= held_next;
            lead_reg  <= lead_next;
            ended_reg <= ended_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/tgac_out_reg.sv =====
`default_nettype none

module tgac_out_reg
    import tgac_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire glyph_beat_t load_beat,
    input  wire logic        out_stall,
    output logic             out_valid,
    output glyph_beat_t      out_beat,
    output logic             free
);

    logic        valid_reg;
    logic        valid_next;
    glyph_beat_t beat_reg;

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;
    assign free      = !valid_reg || !out_stall;

    always_comb
    begin
        priority if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            beat_reg <= load_beat;
    end

endmodule

`default_nettype wire

// ===== design/text_glyph_address_and_cursor.sv =====
// text glyph address and cursor unit
// text channel: text_valid / text_stall carry one text byte per beat, with
//   string_start and the start position that it loads into the cursor
// glyph channel: glyph_valid / glyph_stall carry one glyph request per beat
//   (flash address, byte count, size, screen position, wide flag)
// config channel: cfg_valid / cfg_ready, index 0 font size mode, index 1 font
//   base address; cfg_ready is always high, write only while idle
// a text beat lands in the input register; once the output register is free, one
//   pass of logic builds the request into the output register and updates the cursor
// throughput: one byte per cycle while glyph_stall stays low; lead bytes, end
//   zeros and bytes after the end give no request
// reset: cursor at 0,0, no lead byte waiting, bytes ignored until a beat with
//   string_start; size mode 16 pixels, base 0x020000
// receiver stall: the output register holds its beat, the input register
//   takes one more byte, then text_stall rises until glyph_stall drops
`default_nettype none

module text_glyph_address_and_cursor
    import tgac_pkg::*;
#(
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   text_valid,
    output logic                        text_stall,
    input  wire text_beat_t             text,
    output logic                        glyph_valid,
    input  wire logic                   glyph_stall,
    output glyph_beat_t                 glyph,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    font_cfg_t   font_cfg;
    logic        held_valid;
    text_beat_t  held_beat;
    logic        advance;
    logic        out_free;
    logic        emit;
    glyph_beat_t result;

    assign advance = held_valid && out_free;

    tgac_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .font_cfg  (font_cfg)
    );

    tgac_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (text_valid),
        .in_stall   (text_stall),
        .in_beat    (text),
        .advance    (advance),
        .held_valid (held_valid),
        .held_beat  (held_beat)
    );

    tgac_glyph_unit #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_glyph_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .font_cfg (font_cfg),
        .fire     (advance),
        .beat     (held_beat),
        .emit     (emit),
        .result   (result)
    );

    tgac_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && emit),
        .load_beat (result),
        .out_stall (glyph_stall),
        .out_valid (glyph_valid),
        .out_beat  (glyph),
        .free      (out_free)
    );

endmodule

`default_nettype wire

// ===== design/tgac_checker.sv =====
`default_nettype none

module tgac_checker
    import tgac_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        text_stall,
    input wire logic        glyph_valid,
    input wire logic        glyph_stall,
    input wire glyph_beat_t glyph
);

    // a stalled request holds
    assert property (@(posedge clk) disable iff (!rst_n)
        glyph_valid && glyph_stall |=> glyph_valid && $stable(glyph))
        else $error("glyph beat changed under stall");

    // input backs up only behind a stalled request
    assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> glyph_valid && glyph_stall)
        else $error("text stalled with output free");

    // size, byte count and wide flag form one of the four fonts
    assert property (@(posedge clk) disable iff (!rst_n)
        glyph_valid |->
            (glyph.glyph_bytes == 8'd16 && glyph.glyph_width == 6'd8
             && glyph.glyph_height == 6'd16 && !glyph.is_wide_char)
         || (glyph.glyph_bytes == 8'd64 && glyph.glyph_width == 6'd16
             && glyph.glyph_height == 6'd32 && !glyph.is_wide_char)
         || (glyph.glyph_bytes == 8'd32 && glyph.glyph_width == 6'd16
             && glyph.glyph_height == 6'd16 && glyph.is_wide_char)
         || (glyph.glyph_bytes == 8'd128 && glyph.glyph_width == 6'd32
             && glyph.glyph_height == 6'd32 && glyph.is_wide_char))
        else $error("inconsistent glyph size fields");

endmodule

bind text_glyph_address_and_cursor tgac_checker u_checker (.*);

`default_nettype wire

// ===== tb/text_glyph_address_and_cursor_tb.sv =====
`timescale 1ns / 100ps

module text_glyph_address_and_cursor_tb;
    import tgac_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [31:0] GB_FIRST_CODE = 32'h0000_00A1;
    localparam logic [31:0] GB_ROW_LEN = 32'd94;

    logic clk;
    logic rst_n;
    logic text_valid;
    logic text_stall;
    text_beat_t text;
    logic glyph_valid;
    logic glyph_stall;
    glyph_beat_t glyph;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // model of the block
    logic [15:0] col_pos = '0;
    logic [15:0] row_pos = '0;
    logic [7:0] lead_byte = '0;
    logic lead_held = 1'b0;
    logic text_done = 1'b1;
    logic font_big = 1'b0;
    logic [23:0] font_base = FONT_BASE_RESET;

    glyph_beat_t pending_glyphs[$];
    int unsigned taken_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    logic no_idle = 1'b0;

    text_glyph_address_and_cursor dut (
        .clk(clk),
        .rst_n(rst_n),
        .text_valid(text_valid),
        .text_stall(text_stall),
        .text(text),
        .glyph_valid(glyph_valid),
        .glyph_stall(glyph_stall),
        .glyph(glyph),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        glyph_stall <= !no_idle && ($urandom_range(0, 99) < 37);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("mismatch at cycle %0d, %s: got %0h expected %0h",
                     cycle_count, what, got, want);
    endtask

    task automatic queue_glyph(input logic [31:0] addr, input int unsigned nbytes,
                               input int unsigned w, input int unsigned h,
                               input logic wide);
        glyph_beat_t g;
        logic [15:0] next_col;
        g.glyph_address = addr;
        g.glyph_bytes = 8'(nbytes);
        g.glyph_width = 6'(w);
        g.glyph_height = 6'(h);
        g.draw_x = col_pos;
        g.draw_y = row_pos;
        g.is_wide_char = wide;
        pending_glyphs.push_back(g);
        next_col = col_pos + 16'(w);
        if (int'(next_col) >= SCREEN_WIDTH_DEF - int'(w))
        begin
            next_col = '0;
            row_pos = row_pos + 16'(h);
        end
        col_pos = next_col;
    endtask

    task automatic predict_text(input text_beat_t b);
        logic [31:0] idx;
        if (b.string_start)
        begin
            col_pos = b.start_x;
            row_pos = b.start_y;
            lead_held = 1'b0;
            text_done = 1'b0;
        end
        if (!text_done)
        begin
            taken_count++;
            if (lead_held)
            begin
                idx = ({24'b0, lead_byte} - GB_FIRST_CODE) * GB_ROW_LEN
                      + ({24'b0, b.text_byte} - GB_FIRST_CODE);
                lead_held = 1'b0;
                if (font_big)
                    queue_glyph({8'b0, font_base} + OFS_HZK32 + idx * 32'd128,
                                128, 32, 32, 1'b1);
                else
                    queue_glyph({8'b0, font_base} + OFS_HZK16 + idx * 32'd32,
                                32, 16, 16, 1'b1);
            end
            else if (b.text_byte == 8'h00)
                text_done = 1'b1;
            else if (b.text_byte[7])
            begin
                lead_byte = b.text_byte;
                lead_held = 1'b1;
            end
            else if (font_big)
                queue_glyph({8'b0, font_base} + OFS_ASC32 + {24'b0, b.text_byte} * 32'd64,
                            64, 16, 32, 1'b0);
            else
                queue_glyph({8'b0, font_base} + OFS_ASC16 + {24'b0, b.text_byte} * 32'd16,
                            16, 8, 16, 1'b0);
        end
    endtask

    task automatic check_glyph(input glyph_beat_t got);
        glyph_beat_t want;
        if (pending_glyphs.size() == 0)
            report_mismatch("glyph with none expected", got.glyph_address, '0);
        else
        begin
            want = pending_glyphs.pop_front();
            if (got.glyph_address !== want.glyph_address)
                report_mismatch("glyph_address", got.glyph_address, want.glyph_address);
            if (got.glyph_bytes !== want.glyph_bytes)
                report_mismatch("glyph_bytes", 32'(got.glyph_bytes), 32'(want.glyph_bytes));
            if (got.glyph_width !== want.glyph_width)
                report_mismatch("glyph_width", 32'(got.glyph_width), 32'(want.glyph_width));
            if (got.glyph_height !== want.glyph_height)
                report_mismatch("glyph_height", 32'(got.glyph_height),
                                32'(want.glyph_height));
            if (got.draw_x !== want.draw_x)
                report_mismatch("draw_x", 32'(got.draw_x), 32'(want.draw_x));
            if (got.draw_y !== want.draw_y)
                report_mismatch("draw_y", 32'(got.draw_y), 32'(want.draw_y));
            if (got.is_wide_char !== want.is_wide_char)
                report_mismatch("is_wide_char", 32'(got.is_wide_char),
                                32'(want.is_wide_char));
        end
    endtask

    // config, text and glyph beats seen in one place so their order is fixed
    always @(posedge clk)
    begin
        if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_FONT_SIZE_MODE: font_big = cfg_data[0];
                CFG_FONT_BASE_ADDRESS: font_base = cfg_data;
                default: ;
            endcase
        end
        if (text_valid === 1'b1 && text_stall === 1'b0)
            predict_text(text);
        if (glyph_valid === 1'b1 && glyph_stall === 1'b0)
            check_glyph(glyph);
    end

    function automatic text_beat_t text_item(input logic [7:0] v, input logic s = 1'b0,
                                             input logic [15:0] x = '0,
                                             input logic [15:0] y = '0);
        text_beat_t b;
        b.text_byte = v;
        b.string_start = s;
        b.start_x = x;
        b.start_y = y;
        return b;
    endfunction

    function automatic logic [15:0] rand_pos();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 260));
    endfunction

    task automatic send_text(input text_beat_t b);
        while (!no_idle && $urandom_range(0, 99) < 37)
        begin
            text_valid <= 1'b0;
            text <= text_beat_t'(41'({$urandom, $urandom}));
            @(posedge clk);
        end
        text_valid <= 1'b1;
        text <= b;
        @(posedge clk);
        while (text_stall)
            @(posedge clk);
    endtask

    task automatic settle_block();
        text_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_glyphs.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_ignored_before_start();
        send_text(text_item(8'h41));
        send_text(text_item(8'hA1));
        send_text(text_item(8'h00));
    endtask

    task automatic test_ascii_edges();
        send_text(text_item(8'h01, 1'b1, 16'h0000, 16'h0000));
        send_text(text_item(8'h7F));
        send_text(text_item(8'h20));
    endtask

    task automatic test_wide_pairs();
        send_text(text_item(8'hA1));
        send_text(text_item(8'hA1));
        send_text(text_item(8'hFF));
        send_text(text_item(8'hFF));
        // zero trail still makes a glyph
        send_text(text_item(8'h80));
        send_text(text_item(8'h00));
        send_text(text_item(8'hB0));
        send_text(text_item(8'h7F));
    endtask

    task automatic test_string_end();
        send_text(text_item(8'h00));
        send_text(text_item(8'h41));
        send_text(text_item(8'h00, 1'b1, 16'h1234, 16'h5678));
        // cursor wraps at 16 bits
        send_text(text_item(8'h42, 1'b1, 16'hFFFF, 16'hFFFF));
        send_text(text_item(8'h43));
    endtask

    task automatic test_restart_mid_char();
        send_text(text_item(8'hC4, 1'b1, 16'd40, 16'd8));
        send_text(text_item(8'h41, 1'b1, 16'd230, 16'd100));
        send_text(text_item(8'h42));
    endtask

    task automatic test_size_change_mid_char();
        send_text(text_item(8'hD6, 1'b1, 16'd16, 16'd32));
        settle_block();
        write_reg(CFG_FONT_SIZE_MODE, 24'd1);
        send_text(text_item(8'hD0));
        settle_block();
        write_reg(CFG_FONT_SIZE_MODE, 24'd0);
    endtask

    task automatic test_config_extremes();
        settle_block();
        write_reg(CFG_FONT_BASE_ADDRESS, 24'hFFFFFF);
        write_reg(CFG_FONT_SIZE_MODE, 24'd1);
        send_text(text_item(8'h7F, 1'b1, 16'd200, 16'd0));
        send_text(text_item(8'hFF));
        send_text(text_item(8'hFF));
        settle_block();
        write_reg(CFG_FONT_BASE_ADDRESS, 24'h000000);
        write_reg(CFG_FONT_SIZE_MODE, 24'd0);
        send_text(text_item(8'h01, 1'b1, 16'd0, 16'd0));
    endtask

    task automatic send_random_string();
        int unsigned len;
        int unsigned pick;
        logic [7:0] first;
        len = $urandom_range(2, 24);
        first = 8'($urandom_range(1, 255));
        send_text(text_item(first, 1'b1, rand_pos(), rand_pos()));
        if (first[7])
            send_text(text_item(8'($urandom_range(0, 255))));
        repeat (len)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_text(text_item(8'($urandom_range(1, 127))));
            else if (pick < 85)
            begin
                send_text(text_item(8'($urandom_range(128, 255))));
                send_text(text_item(8'($urandom_range(0, 255))));
            end
            else if (pick < 93)
                send_text(text_item(8'($urandom_range(0, 255)), 1'b0,
                                    16'($urandom), 16'($urandom)));
            else
                send_text(text_item(8'($urandom_range(0, 255)), 1'b1,
                                    rand_pos(), rand_pos()));
        end
        if ($urandom_range(0, 3) != 0)
            send_text(text_item(8'h00));
        if ($urandom_range(0, 3) == 0)
        begin
            send_text(text_item(8'($urandom_range(0, 255)), 1'b0,
                                16'($urandom), 16'($urandom)));
            send_text(text_item(8'($urandom_range(0, 255)), 1'b0,
                                16'($urandom), 16'($urandom)));
        end
    endtask

    task automatic test_random_text(input int unsigned target);
        int unsigned phase_goal;
        logic paused;
        paused = 1'b0;
        for (int p = 0; p < 6; p++)
        begin
            settle_block();
            write_reg(CFG_FONT_SIZE_MODE, 24'(p % 2));
            case (p)
                1: write_reg(CFG_FONT_BASE_ADDRESS, 24'hFFFFFF);
                2: write_reg(CFG_FONT_BASE_ADDRESS, 24'h000000);
                4: write_reg(CFG_FONT_BASE_ADDRESS, FONT_BASE_RESET);
                default: write_reg(CFG_FONT_BASE_ADDRESS, 24'($urandom));
            endcase
            no_idle = (p == 2);
            phase_goal = taken_count + target / 6;
            while (taken_count < phase_goal)
            begin
                send_random_string();
                // hold off until every glyph so far has come out
                if (p == 3 && !paused && taken_count + target / 12 > phase_goal)
                begin
                    settle_block();
                    paused = 1'b1;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        text_valid = 1'b0;
        text = '0;
        glyph_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FONT_SIZE_MODE;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ignored_before_start();
        test_ascii_edges();
        test_wide_pairs();
        test_string_end();
        test_restart_mid_char();
        test_size_change_mid_char();
        test_config_extremes();
        test_random_text(650);

        settle_block();
        repeat (8) @(posedge clk);
        if (pending_glyphs.size() != 0)
            report_mismatch("glyphs never seen", 32'(pending_glyphs.size()), '0);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tgac_pkg.sv
design/tgac_cfg_regs.sv
design/tgac_in_reg.sv
design/tgac_glyph_unit.sv
design/tgac_out_reg.sv
design/text_glyph_address_and_cursor.sv
design/tgac_checker.sv
tb/text_glyph_address_and_cursor_tb.sv
